@@ hdl/deq_pkg.sv @@
// Shared types and codes for the double-ended queue.
`timescale 1ns / 1ps
package deq_pkg;

	// Beat field widths fixed by the interface
	localparam int OPCODE_W = 3;
	localparam int BEAT_VALUE_W = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W = 11;

	// Operation codes; unlisted codes behave as a query
	localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [OPCODE_W-1:0] OP_PUSH_BACK = 3'd1;
	localparam logic [OPCODE_W-1:0] OP_POP_FRONT = 3'd2;
	localparam logic [OPCODE_W-1:0] OP_POP_BACK = 3'd3;
	localparam logic [OPCODE_W-1:0] OP_QUERY = 3'd4;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
	localparam logic [STATUS_W-1:0] ST_POP_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_PUSH_FULL = 2'd2;

	typedef struct packed {
		logic [OPCODE_W-1:0] opcode;
		logic signed [BEAT_VALUE_W-1:0] push_value;
	} req_beat_t;

	typedef struct packed {
		logic signed [BEAT_VALUE_W-1:0] popped_value;
		logic [STATUS_W-1:0] status;
		logic [COUNT_W-1:0] entry_count;
		logic is_empty;
		logic signed [BEAT_VALUE_W-1:0] front_value;
		logic signed [BEAT_VALUE_W-1:0] back_value;
	} rsp_beat_t;

endpackage

@@ hdl/double_ended_queue_top.sv @@
// Double-ended queue: ring buffer in a synchronous memory plus front/back caches.
// A response beat is loaded into the output register once the accepted request has updated
// the queue state, unless the output is stalled. One request is in flight at a time, so the
// memory read that fetches the new front or back entry after a pop lands before the next is accepted.
// Reset clears head pointer, count and handshake state; the entry memory is not
// cleared and needs no clearing pass.
`timescale 1ns / 1ps
module double_ended_queue_top #(
	parameter int DEPTH = 1024,
	parameter int VALUE_WIDTH = 32
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_stall,
	input deq_pkg::req_beat_t req_beat,
	output logic rsp_valid,
	input logic rsp_stall,
	output deq_pkg::rsp_beat_t rsp_beat
);
	import deq_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = AW + 1;
	localparam int XW = (VALUE_WIDTH > BEAT_VALUE_W) ? VALUE_WIDTH : BEAT_VALUE_W;
	localparam int KW = (CW > COUNT_W) ? CW : COUNT_W;

	// Entry memory: one write and one registered read per cycle
	logic [VALUE_WIDTH-1:0] mem [DEPTH];
	logic [VALUE_WIDTH-1:0] rd_data_q;
	logic wr_en, rd_en;
	logic [AW-1:0] wr_addr, rd_addr;
	logic [VALUE_WIDTH-1:0] wr_val;

	// Queue state
	logic [AW-1:0] head_q, head_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [VALUE_WIDTH-1:0] front_q, front_d, back_q, back_d;

	// Pending result of the item in flight
	logic busy_q, s1_q;
	logic upd_front_q, upd_front_d, upd_back_q, upd_back_d;
	logic [STATUS_W-1:0] status_q, status_d;
	logic [VALUE_WIDTH-1:0] popped_q, popped_d;

	// Output register
	logic rsp_valid_q;
	rsp_beat_t rsp_q;

	logic accept, load;
	logic is_full, is_empty;
	logic [XW-1:0] push_ext;
	logic [AW-1:0] head_dec, head_inc, tail_push, tail_pop;
	logic [SW-1:0] inc_sum, push_sum, pop_sum;

	assign accept = req_valid & ~busy_q;
	assign req_stall = busy_q;
	assign load = busy_q & (~rsp_valid_q | ~rsp_stall);

	assign push_ext = XW'($unsigned(req_beat.push_value));
	assign wr_val = push_ext[VALUE_WIDTH-1:0];
	assign is_full = (cnt_q == CW'(DEPTH));
	assign is_empty = (cnt_q == '0);

	// Ring index arithmetic: every sum stays below twice the depth
	assign head_dec = (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);
	assign inc_sum = SW'(head_q) + SW'(1);
	assign head_inc = (inc_sum >= SW'(DEPTH)) ? AW'(inc_sum - SW'(DEPTH)) : inc_sum[AW-1:0];
	assign push_sum = SW'(head_q) + SW'(cnt_q);
	assign tail_push = (push_sum >= SW'(DEPTH)) ? AW'(push_sum - SW'(DEPTH))
		: push_sum[AW-1:0];
	// new back slot after a pop from the back (count of at least two)
	assign pop_sum = SW'(head_q) + SW'(cnt_q) - SW'(2);
	assign tail_pop = (pop_sum >= SW'(DEPTH)) ? AW'(pop_sum - SW'(DEPTH)) : pop_sum[AW-1:0];

	// Operation decode and next state
	always_comb begin
		head_d = head_q;
		cnt_d = cnt_q;
		front_d = front_q;
		back_d = back_q;
		wr_en = 1'b0;
		wr_addr = tail_push;
		rd_en = 1'b0;
		rd_addr = head_inc;
		status_d = ST_OK;
		popped_d = '0;
		upd_front_d = 1'b0;
		upd_back_d = 1'b0;
		unique case (req_beat.opcode)
			OP_PUSH_FRONT: begin
				if (is_full) begin
					status_d = ST_PUSH_FULL;
				end else begin
					head_d = head_dec;
					cnt_d = cnt_q + CW'(1);
					wr_en = 1'b1;
					wr_addr = head_dec;
					front_d = wr_val;
					if (is_empty) begin
						back_d = wr_val;
					end
				end
			end
			OP_PUSH_BACK: begin
				if (is_full) begin
					status_d = ST_PUSH_FULL;
				end else begin
					cnt_d = cnt_q + CW'(1);
					wr_en = 1'b1;
					back_d = wr_val;
					if (is_empty) begin
						front_d = wr_val;
					end
				end
			end
			OP_POP_FRONT: begin
				if (is_empty) begin
					status_d = ST_POP_EMPTY;
				end else begin
					popped_d = front_q;
					head_d = head_inc;
					cnt_d = cnt_q - CW'(1);
					// refetch the front unless the queue drains
					if (cnt_q != CW'(1)) begin
						rd_en = 1'b1;
						upd_front_d = 1'b1;
					end
				end
			end
			OP_POP_BACK: begin
				if (is_empty) begin
					status_d = ST_POP_EMPTY;
				end else begin
					popped_d = back_q;
					cnt_d = cnt_q - CW'(1);
					if (cnt_q != CW'(1)) begin
						rd_en = 1'b1;
						rd_addr = tail_pop;
						upd_back_d = 1'b1;
					end
				end
			end
			default: begin
				// query and unused codes change nothing
			end
		endcase
	end

	// Memory ports; a read never targets the slot written by the same item,
	// and busy keeps the next item out until the read has landed
	always_ff @(posedge clk) begin
		if (accept && wr_en) begin
			mem[wr_addr] <= wr_val;
		end
		if (accept && rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			cnt_q <= '0;
			busy_q <= 1'b0;
			s1_q <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			s1_q <= accept;
			if (accept) begin
				head_q <= head_d;
				cnt_q <= cnt_d;
				busy_q <= 1'b1;
			end else if (load) begin
				busy_q <= 1'b0;
			end
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Front/back caches and pending result fields
	logic [VALUE_WIDTH-1:0] front_now, back_now;

	assign front_now = (s1_q && upd_front_q) ? rd_data_q : front_q;
	assign back_now = (s1_q && upd_back_q) ? rd_data_q : back_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			front_q <= front_d;
			back_q <= back_d;
			status_q <= status_d;
			popped_q <= popped_d;
			upd_front_q <= upd_front_d;
			upd_back_q <= upd_back_d;
		end else if (s1_q) begin
			front_q <= front_now;
			back_q <= back_now;
		end
	end

	// Response formatting
	logic [XW-1:0] popped_ext, front_ext, back_ext;
	logic [KW-1:0] cnt_ext;
	logic now_empty;

	assign now_empty = (cnt_q == '0);
	assign popped_ext = XW'(popped_q);
	assign front_ext = now_empty ? '0 : XW'(front_now);
	assign back_ext = now_empty ? '0 : XW'(back_now);
	assign cnt_ext = KW'(cnt_q);

	always_ff @(posedge clk) begin
		if (load) begin
			rsp_q.popped_value <= $signed(popped_ext[BEAT_VALUE_W-1:0]);
			rsp_q.status <= status_q;
			rsp_q.entry_count <= cnt_ext[COUNT_W-1:0];
			rsp_q.is_empty <= now_empty;
			rsp_q.front_value <= $signed(front_ext[BEAT_VALUE_W-1:0]);
			rsp_q.back_value <= $signed(back_ext[BEAT_VALUE_W-1:0]);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_beat = rsp_q;

endmodule

@@ hdl/deq_checker.sv @@
// Port-level checks for the double-ended queue, bound to the top level.
`timescale 1ns / 1ps
module deq_checker (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input deq_pkg::req_beat_t req_beat,
	input logic rsp_valid,
	input logic rsp_stall,
	input deq_pkg::rsp_beat_t rsp_beat
);
	import deq_pkg::*;

	// A stalled response beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_beat))
		else $error("response beat changed while stalled");

	// One item in flight: the request side stalls right after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request accepted while previous item in flight");

	// An empty queue reports zero count and zero ends
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_beat.is_empty |->
		rsp_beat.entry_count == '0 && rsp_beat.front_value == '0 &&
		rsp_beat.back_value == '0)
		else $error("empty queue reports nonzero fields");

	// A pop on empty removes nothing and leaves the queue empty
	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_beat.status == ST_POP_EMPTY |->
		rsp_beat.popped_value == '0 && rsp_beat.is_empty)
		else $error("pop on empty reports data or entries");

	// A dropped push means the queue is full, never empty
	a_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_beat.status == ST_PUSH_FULL |->
		rsp_beat.popped_value == '0 && !rsp_beat.is_empty)
		else $error("dropped push with empty queue or popped data");

endmodule

bind double_ended_queue_top deq_checker u_deq_checker (.*);
